[design/raster_2x2_box_downsample_top_macros.svh]
// ----------------------------------------------------------------------------
// raster_2x2_box_downsample_top_macros.svh
// Assertion macros for the 2x2 box downsampler. Defining NO_ASSERTIONS turns
// every check into an empty statement.
// ----------------------------------------------------------------------------
`ifndef RASTER_2X2_BOX_DOWNSAMPLE_TOP_MACROS_SVH
`define RASTER_2X2_BOX_DOWNSAMPLE_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, checked at every rising edge outside reset.
`define R2BD_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("r2bd: same-cycle check failed");
// Next-cycle implication, checked at every rising edge outside reset.
`define R2BD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("r2bd: next-cycle check failed");
`else
`define R2BD_ASSERT_IMPL(label, clk, rst, ante, cons)
`define R2BD_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

[design/r2bd_pkg.sv]
// ----------------------------------------------------------------------------
// r2bd_pkg
// Widths, register map and shared types of the 2x2 box downsampler.
// ----------------------------------------------------------------------------
`default_nettype none

package r2bd_pkg;

  // Field and datapath widths.
  localparam int SAMPLE_W = 16;
  localparam int PAIR_W   = 17;
  localparam int SUM_W    = 18;
  localparam int WIDTH_W  = 15;
  localparam int ROW_W    = 14;

  // Configuration port.
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  // Register indexes, taken from paddr[2].
  localparam logic REG_IMAGE_WIDTH = 1'b0;
  localparam logic REG_BYTE_SWAP   = 1'b1;

  // Register reset values and the smallest usable row length.
  localparam logic [WIDTH_W-1:0] IMAGE_WIDTH_RESET = 15'd16384;
  localparam logic [WIDTH_W-1:0] MIN_WIDTH         = 15'd4;

  // A second-row pair on its way to the rounding stage.
  typedef struct packed {
    logic signed [PAIR_W-1:0] pair;
    logic                     row_end;
    logic                     frame_end;
  } pair_req_t;

  // Status of the rounding stage.
  typedef struct packed {
    logic busy;     // stage holds a pair not yet moved on to the output register
    logic advance;  // pipeline moves this cycle
  } stage_stat_t;

endpackage

`default_nettype wire

[design/r2bd_line_store.sv]
// ----------------------------------------------------------------------------
// r2bd_line_store
// Single-port line store of horizontal pair sums with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module r2bd_line_store #(
  parameter int DEPTH = 8192,
  parameter int IDX_W = 13
) (
  input  logic                                clk,
  input  logic                                we,
  input  logic                                re,
  input  logic [IDX_W-1:0]                    addr,
  input  logic signed [r2bd_pkg::PAIR_W-1:0]  wdata,
  output logic signed [r2bd_pkg::PAIR_W-1:0]  rdata
);
  import r2bd_pkg::*;

  logic signed [PAIR_W-1:0] mem [DEPTH];

  // One access per cycle; the read data holds until the next read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

`default_nettype wire

[design/r2bd_pair_front.sv]
// ----------------------------------------------------------------------------
// r2bd_pair_front
// Input stage: byte swap, horizontal pair sums, raster position counters and
// line-store access generation.
// ----------------------------------------------------------------------------
`default_nettype none

module r2bd_pair_front #(
  parameter int IDX_W    = 13,
  parameter int IDX_MASK = 8191
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 accept,
  input  logic                                 restart,
  input  logic                                 byte_swap,
  input  logic [r2bd_pkg::WIDTH_W-1:0]         width_eff,
  input  logic [r2bd_pkg::SAMPLE_W-1:0]        raw_sample,
  output logic                                 mem_we,
  output logic                                 mem_re,
  output logic [IDX_W-1:0]                     mem_addr,
  output logic signed [r2bd_pkg::PAIR_W-1:0]   mem_wdata,
  output r2bd_pkg::pair_req_t                  req
);
  import r2bd_pkg::*;

  logic [SAMPLE_W-1:0]      held_sample;
  logic [WIDTH_W-1:0]       col;
  logic [ROW_W-1:0]         row;
  logic [SAMPLE_W-1:0]      sample;
  logic signed [PAIR_W-1:0] pair;
  logic                     last_col;
  logic                     last_row;
  logic [ROW_W-1:0]         last_row_idx;
  logic [31:0]              half_col;

  // Optional byte swap of the incoming word.
  assign sample = byte_swap ? {raw_sample[7:0], raw_sample[15:8]} : raw_sample;

  // Sum of the held even-column sample and this odd-column sample.
  assign pair = $signed({held_sample[SAMPLE_W-1], held_sample})
              + $signed({sample[SAMPLE_W-1], sample});

  // Frame height is (width / 4) * 2 rows, so the last row index ends in a one.
  assign last_row_idx = {width_eff[WIDTH_W-1:2] - 13'd1, 1'b1};
  assign last_col     = (col == width_eff - 15'd1);
  assign last_row     = (row == last_row_idx);

  // Line-store entry of this pair.
  assign half_col = 32'(col[WIDTH_W-1:1]) & 32'(IDX_MASK);
  assign mem_addr = half_col[IDX_W-1:0];

  // First row of a pair of rows writes its pair sums, the second row reads them.
  assign mem_we    = accept & col[0] & ~row[0];
  assign mem_re    = accept & col[0] & row[0];
  assign mem_wdata = pair;

  assign req.pair      = pair;
  assign req.row_end   = last_col;
  assign req.frame_end = last_col & last_row;

  // Position counters and the held sample.
  always_ff @(posedge clk) begin
    if (rst || restart) begin
      held_sample <= '0;
      col         <= '0;
      row         <= '0;
    end else if (accept) begin
      if (!col[0]) begin
        held_sample <= sample;
      end
      if (last_col) begin
        col <= '0;
        row <= last_row ? '0 : row + 14'd1;
      end else begin
        col <= col + 15'd1;
      end
    end
  end

endmodule

`default_nettype wire

[design/r2bd_round_out.sv]
// ----------------------------------------------------------------------------
// r2bd_round_out
// Joins a second-row pair with its line-store partner, rounds the quarter of
// the four-sample sum and holds the result in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module r2bd_round_out (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                load,
  input  r2bd_pkg::pair_req_t                 req,
  input  logic signed [r2bd_pkg::PAIR_W-1:0]  rdata,
  input  logic                                out_ready,
  output logic                                out_valid,
  output logic signed [r2bd_pkg::SAMPLE_W-1:0] half_sample,
  output logic                                row_end,
  output logic                                frame_end,
  output r2bd_pkg::stage_stat_t               stat
);
  import r2bd_pkg::*;

  logic                     s1_valid;
  pair_req_t                s1_req;
  logic                     adv;
  logic signed [SUM_W-1:0]  sum;
  logic [SUM_W-1:0]         mag;
  logic [SUM_W-1:0]         mag_rnd;
  logic [SAMPLE_W-1:0]      quot;
  logic [SAMPLE_W-1:0]      res;

  // The output register moves whenever it is free or being drained.
  assign adv          = ~out_valid | out_ready;
  assign stat.busy    = s1_valid;
  assign stat.advance = adv;

  // Round half away from zero: sign * ((|sum| + 2) >> 2).
  assign sum     = SUM_W'(rdata) + SUM_W'(s1_req.pair);
  assign mag     = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
  assign mag_rnd = mag + 18'd2;
  assign quot    = mag_rnd[SAMPLE_W+1:2];
  assign res     = sum[SUM_W-1] ? SAMPLE_W'(-quot) : quot;

  // Stage valid and output valid. The stage fills on a load and empties when
  // its pair moves into the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (adv) begin
        out_valid <= s1_valid;
      end
      if (load) begin
        s1_valid <= 1'b1;
      end else if (adv) begin
        s1_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (load) begin
      s1_req <= req;
    end
    if (adv && s1_valid) begin
      half_sample <= $signed(res);
      row_end     <= s1_req.row_end;
      frame_end   <= s1_req.frame_end;
    end
  end

endmodule

`default_nettype wire

[design/raster_2x2_box_downsample_top.sv]
// ----------------------------------------------------------------------------
// raster_2x2_box_downsample_top
// 2x2 box-filter downsampler for a raster of signed 16-bit samples.
// ----------------------------------------------------------------------------
// The block takes one raw sample per cycle while in_ready is high, in
// row-major order, and gives one rounded 2x2 mean for every second sample
// of every second row, with row and frame end marks. Sustained rate is one
// input beat per clock while in_ready holds, and each beat makes at most one
// access to the single-port line store. Input ready drops only while a
// finished result waits in the output register and the stage behind it is
// full. The line store needs no clearing pass, as every entry is written in
// the first row of a row pair before it is read. Writing image_width restarts
// the frame; write registers only while idle.
`default_nettype none

`include "raster_2x2_box_downsample_top_macros.svh"

module raster_2x2_box_downsample_top #(
  parameter int MAX_WIDTH = 16384
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // Configuration port
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [r2bd_pkg::ADDR_W-1:0]           paddr,
  input  logic [r2bd_pkg::DATA_W-1:0]           pwdata,
  output logic [r2bd_pkg::DATA_W-1:0]           prdata,
  output logic                                  pready,
  // Sample input
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [r2bd_pkg::SAMPLE_W-1:0]         raw_sample,
  // Result output
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [r2bd_pkg::SAMPLE_W-1:0]  half_sample,
  output logic                                  row_end,
  output logic                                  frame_end
);
  import r2bd_pkg::*;

  localparam int DEPTH    = MAX_WIDTH / 2;
  localparam int IDX_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int IDX_MASK = DEPTH - 1;

  logic [WIDTH_W-1:0]       image_width;
  logic                     byte_swap;
  logic                     cfg_wr;
  logic                     width_wr;
  logic [WIDTH_W-1:0]       width_cap;
  logic [WIDTH_W-1:0]       width_even;
  logic [WIDTH_W-1:0]       width_eff;
  logic                     accept;
  logic                     mem_we;
  logic                     mem_re;
  logic [IDX_W-1:0]         mem_addr;
  logic signed [PAIR_W-1:0] mem_wdata;
  logic signed [PAIR_W-1:0] mem_rdata;
  pair_req_t                req;
  stage_stat_t              stat;

  // Register writes and reads.
  assign pready   = 1'b1;
  assign cfg_wr   = psel & penable & pwrite & pready;
  assign width_wr = cfg_wr & (paddr[2] == REG_IMAGE_WIDTH);

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width <= IMAGE_WIDTH_RESET;
      byte_swap   <= 1'b0;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_IMAGE_WIDTH: image_width <= pwdata[WIDTH_W-1:0];
        REG_BYTE_SWAP:   byte_swap   <= pwdata[0];
        default:         byte_swap   <= byte_swap;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_IMAGE_WIDTH: prdata = DATA_W'(image_width);
      REG_BYTE_SWAP:   prdata = DATA_W'(byte_swap);
      default:         prdata = '0;
    endcase
  end

  // Usable row length: limited to the line store, even, and at least four.
  assign width_cap  = ({2'b00, image_width} > 17'(MAX_WIDTH)) ? WIDTH_W'(MAX_WIDTH)
                                                             : image_width;
  assign width_even = {width_cap[WIDTH_W-1:1], 1'b0};
  assign width_eff  = (width_even < MIN_WIDTH) ? MIN_WIDTH : width_even;

  // Input handshake: the rounding stage can take a pair when it is empty or
  // moving on into the output register.
  assign in_ready = ~stat.busy | stat.advance;
  assign accept   = in_valid & in_ready;

  r2bd_pair_front #(
    .IDX_W    (IDX_W),
    .IDX_MASK (IDX_MASK)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .restart    (width_wr),
    .byte_swap  (byte_swap),
    .width_eff  (width_eff),
    .raw_sample (raw_sample),
    .mem_we     (mem_we),
    .mem_re     (mem_re),
    .mem_addr   (mem_addr),
    .mem_wdata  (mem_wdata),
    .req        (req)
  );

  r2bd_line_store #(
    .DEPTH (DEPTH),
    .IDX_W (IDX_W)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .re    (mem_re),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  r2bd_round_out u_round (
    .clk         (clk),
    .rst         (rst),
    .load        (mem_re),
    .req         (req),
    .rdata       (mem_rdata),
    .out_ready   (out_ready),
    .out_valid   (out_valid),
    .half_sample (half_sample),
    .row_end     (row_end),
    .frame_end   (frame_end),
    .stat        (stat)
  );

  // A frame ends only on the last result of a row.
  `R2BD_ASSERT_IMPL(a_frame_end_on_row_end, clk, rst, out_valid && frame_end, row_end)
  // The single line-store port never sees a read and a write together.
  `R2BD_ASSERT_IMPL(a_one_store_access, clk, rst, mem_we || mem_re, mem_we != mem_re)
  // A line-store read always fills the rounding stage on the next cycle.
  `R2BD_ASSERT_NEXT(a_read_fills_stage, clk, rst, mem_re, stat.busy)

endmodule

`default_nettype wire

[test/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the 2x2 box downsampler. A short table of directed
// beats covers the sample extremes, rounding of halves away from zero, byte
// swapping and an out-of-range width. Random phases follow that sweep the row
// width, swap setting and handshake pressure. Every beat that is taken runs
// through a bit-exact model of the block, and each result beat is checked in
// order against the expected means, from the table where typed, else the model.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  import r2bd_pkg::*;

  localparam int MAX_W        = 16384;
  localparam int LINE_DEPTH   = MAX_W / 2;
  localparam int SETTLE       = 6;     // output register sits behind the rounding stage
  localparam int QUIET_LIMIT  = 4000;

  localparam logic [ADDR_W-1:0] ADDR_IMAGE_WIDTH = {REG_IMAGE_WIDTH, 2'b00};
  localparam logic [ADDR_W-1:0] ADDR_BYTE_SWAP   = {REG_BYTE_SWAP, 2'b00};

  // One result beat: the rounded block mean and its end marks.
  typedef struct packed {
    logic [SAMPLE_W-1:0] half;
    logic                row_end;
    logic                frame_end;
  } mean_t;

  typedef enum logic [1:0] {DIR_BEAT, DIR_WIDTH, DIR_SWAP} dir_op_e;

  typedef struct packed {
    dir_op_e             op;
    logic [15:0]         value;
    logic                typed;
    mean_t               want;
  } dir_row_t;

  localparam mean_t NO_MEAN = '0;

  // Directed rows. Frames are 4 wide and 2 high, so every eight beats make
  // two means; the second one closes both the row and the frame.
  localparam int N_DIR = 29;
  localparam dir_row_t DIRECTED [N_DIR] = '{
    '{DIR_BEAT,  16'h1234, 1'b0, NO_MEAN},
    '{DIR_BEAT,  16'hABCD, 1'b0, NO_MEAN},
    '{DIR_WIDTH, 16'd0,    1'b0, NO_MEAN},
    // Largest and smallest samples.
    '{DIR_BEAT,  16'h7FFF, 1'b0, NO_MEAN},
    '{DIR_BEAT,  16'h7FFF, 1'b0, NO_MEAN},
    '{DIR_BEAT,  16'h8000, 1'b0, NO_MEAN},
    '{DIR_BEAT,  16'h8000, 1'b0, NO_MEAN},
    '{DIR_BEAT,  16'h7FFF, 1'b0, NO_MEAN},
    '{DIR_BEAT,  16'h7FFF, 1'b1, '{16'h7FFF, 1'b0, 1'b0}},
    '{DIR_BEAT,  16'h8000, 1'b0, NO_MEAN},
    '{DIR_BEAT,  16'h8000, 1'b1, '{16'h8000, 1'b1, 1'b1}},
    // Halves round away from zero on both sides.
    '{DIR_BEAT,  16'h0001, 1'b0, NO_MEAN},
    '{DIR_BEAT,  16'h0001, 1'b0, NO_MEAN},
    '{DIR_BEAT,  16'hFFFF, 1'b0, NO_MEAN},
    '{DIR_BEAT,  16'hFFFF, 1'b0, NO_MEAN},
    '{DIR_BEAT,  16'h0000, 1'b0, NO_MEAN},
    '{DIR_BEAT,  16'h0000, 1'b1, '{16'h0001, 1'b0, 1'b0}},
    '{DIR_BEAT,  16'h0000, 1'b0, NO_MEAN},
    '{DIR_BEAT,  16'h0000, 1'b1, '{16'hFFFF, 1'b1, 1'b1}},
    // Byte swap on.
    '{DIR_SWAP,  16'd1,    1'b0, NO_MEAN},
    '{DIR_BEAT,  16'h0100, 1'b0, NO_MEAN},
    '{DIR_BEAT,  16'h0100, 1'b0, NO_MEAN},
    '{DIR_BEAT,  16'hFF7F, 1'b0, NO_MEAN},
    '{DIR_BEAT,  16'hFF7F, 1'b0, NO_MEAN},
    '{DIR_BEAT,  16'h0100, 1'b0, NO_MEAN},
    '{DIR_BEAT,  16'h0000, 1'b1, '{16'h0001, 1'b0, 1'b0}},
    '{DIR_BEAT,  16'hFF7F, 1'b0, NO_MEAN},
    '{DIR_BEAT,  16'h0080, 1'b1, '{16'h3FFF, 1'b1, 1'b1}},
    '{DIR_SWAP,  16'd0,    1'b0, NO_MEAN}
  };

  // Random phases: width written first, then a count of beats. A zero count
  // means a random number of beats; at full width the beats stay in the
  // first row, so only line-store writes happen there.
  localparam int N_PHASES = 14;
  localparam int PHASE_WIDTH [N_PHASES] =
    '{8, 6, 5, 2, 12, 16384, 10, 16, 3, 32767, 4, 14, 24, 7};
  localparam int PHASE_BEATS [N_PHASES] =
    '{0, 0, 0, 0, 0, 50, 0, 0, 0, 0, 0, 0, 0, 0};

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [ADDR_W-1:0]   paddr = '0;
  logic [DATA_W-1:0]   pwdata = '0;
  logic [DATA_W-1:0]   prdata;
  logic                pready;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [SAMPLE_W-1:0] raw_sample = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic signed [SAMPLE_W-1:0] half_sample;
  logic                row_end;
  logic                frame_end;

  // Model state.
  logic [WIDTH_W-1:0]       model_width = IMAGE_WIDTH_RESET;
  logic                     model_swap = 1'b0;
  logic signed [SAMPLE_W-1:0] held_word = '0;
  logic signed [PAIR_W-1:0] pair_line [LINE_DEPTH];
  logic [WIDTH_W-1:0]       col_pos = '0;
  logic [ROW_W-1:0]         row_pos = '0;

  mean_t pending_means [$];
  int    mismatch_count = 0;
  int    quiet_cycles = 0;
  int    src_idle_pct = 0;
  int    sink_stall_pct = 0;

  always #1 clk = ~clk;

  raster_2x2_box_downsample_top #(
    .MAX_WIDTH(MAX_W)
  ) u_dut (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .raw_sample (raw_sample),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .half_sample(half_sample),
    .row_end    (row_end),
    .frame_end  (frame_end)
  );

  // Advance the model by one sample beat; returns 1 when a mean comes out.
  function automatic bit downsample_step(input logic [SAMPLE_W-1:0] raw, output mean_t m);
    int w;
    int rows;
    int s;
    int pair;
    int sum;
    int mag;
    int q;
    int idx;
    logic [SAMPLE_W-1:0] word;
    bit made;
    made = 1'b0;
    m = '0;
    // Effective width: clamped, even, and never below the minimum.
    w = int'(model_width);
    if (w > MAX_W) w = MAX_W;
    w = w & ~1;
    if (w < MIN_WIDTH) w = MIN_WIDTH;
    rows = (w / 4) * 2;
    word = model_swap ? {raw[7:0], raw[15:8]} : raw;
    s = $signed(word);
    if (col_pos >= w) col_pos = '0;
    if (row_pos >= rows) row_pos = '0;
    // Even columns hold the sample; odd columns close a horizontal pair.
    if (!col_pos[0]) begin
      held_word = word;
    end else begin
      pair = held_word + s;
      idx = int'(col_pos >> 1) & (LINE_DEPTH - 1);
      if (!row_pos[0]) begin
        pair_line[idx] = PAIR_W'(pair);
      end else begin
        sum = pair_line[idx] + pair;
        mag = (sum < 0) ? -sum : sum;
        q = (mag + 2) >> 2;
        m.half = SAMPLE_W'((sum < 0) ? -q : q);
        m.row_end = (col_pos == w - 1);
        m.frame_end = m.row_end && (row_pos == rows - 1);
        made = 1'b1;
      end
    end
    col_pos = col_pos + 1'b1;
    if (col_pos >= w) begin
      col_pos = '0;
      row_pos = row_pos + 1'b1;
      if (row_pos >= rows) row_pos = '0;
    end
    return made;
  endfunction

  // Raw words lean toward the extremes and the byte-swapped extremes.
  function automatic logic [SAMPLE_W-1:0] pick_raw_word();
    case ($urandom_range(0, 7))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'hFFFF;
      3: return 16'h0000;
      4: return $urandom_range(0, 1) ? 16'hFF7F : 16'h0080;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    mismatch_count++;
  endtask

  // Send one sample beat, then queue the mean it should cause.
  task automatic feed_sample(input logic [SAMPLE_W-1:0] raw, input bit typed,
                             input mean_t typed_mean);
    mean_t m;
    bit made;
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    raw_sample <= raw;
    do @(posedge clk); while (!in_ready);
    made = downsample_step(raw, m);
    if (typed) pending_means.push_back(typed_mean);
    else if (made) pending_means.push_back(m);
  endtask

  // Write a register once the block has drained.
  task automatic write_register(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
    in_valid <= 1'b0;
    while (pending_means.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    // A width write restarts the frame.
    if (addr == ADDR_IMAGE_WIDTH) begin
      model_width = data[WIDTH_W-1:0];
      held_word = '0;
      col_pos = '0;
      row_pos = '0;
    end else if (addr == ADDR_BYTE_SWAP) begin
      model_swap = data[0];
    end
  endtask

  // Result side: check each beat taken, then pick the next ready level.
  always @(posedge clk) begin
    mean_t exp_mean;
    if (!rst && out_valid && out_ready) begin
      if (pending_means.size() == 0) begin
        report_mismatch($sformatf("mean %h with none pending", half_sample));
      end else begin
        exp_mean = pending_means.pop_front();
        if (half_sample !== exp_mean.half)
          report_mismatch($sformatf("half_sample %h, expected %h", half_sample, exp_mean.half));
        if (row_end !== exp_mean.row_end)
          report_mismatch($sformatf("row_end %b, expected %b", row_end, exp_mean.row_end));
        if (frame_end !== exp_mean.frame_end)
          report_mismatch($sformatf("frame_end %b, expected %b",
                                    frame_end, exp_mean.frame_end));
      end
    end
    out_ready <= ($urandom_range(0, 99) >= sink_stall_pct);
  end

  // Watchdog on cycles in which nothing moves.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("raster_2x2_box_downsample_top test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Stimulus.
  initial begin
    int beats;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed table.
    for (int i = 0; i < N_DIR; i++) begin
      case (DIRECTED[i].op)
        DIR_WIDTH: write_register(ADDR_IMAGE_WIDTH, DATA_W'(DIRECTED[i].value));
        DIR_SWAP:  write_register(ADDR_BYTE_SWAP, DATA_W'(DIRECTED[i].value));
        default:   feed_sample(DIRECTED[i].value, DIRECTED[i].typed, DIRECTED[i].want);
      endcase
    end

    // Random phases, cycling through the handshake pressure modes.
    for (int p = 0; p < N_PHASES; p++) begin
      write_register(ADDR_IMAGE_WIDTH, DATA_W'(PHASE_WIDTH[p]));
      write_register(ADDR_BYTE_SWAP, DATA_W'($urandom_range(0, 1)));
      case (p % 4)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 73; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 73; end
        default: begin src_idle_pct = 24; sink_stall_pct = 24; end
      endcase
      beats = (PHASE_BEATS[p] != 0) ? PHASE_BEATS[p] : $urandom_range(36, 68);
      for (int n = 0; n < beats; n++) feed_sample(pick_raw_word(), 1'b0, NO_MEAN);
    end

    // Drain and finish.
    in_valid <= 1'b0;
    while (pending_means.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("raster_2x2_box_downsample_top test passed");
    end else begin
      $display("raster_2x2_box_downsample_top test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

[sim.f]
+incdir+design
design/r2bd_pkg.sv
design/r2bd_line_store.sv
design/r2bd_pair_front.sv
design/r2bd_round_out.sv
design/raster_2x2_box_downsample_top.sv
test/tb_top.sv
